/* design/qrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Field widths of the result word, root kind codes and pipeline flags.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int DISC_W       = 35;  // discriminant, signed Q34.0
    localparam int ROOT_W       = 40;  // each root, signed Q23.16
    localparam int ROOT_FRAC    = 16;  // fraction bits of a root
    localparam int KIND_W       = 2;
    localparam int SQRT_IN_W    = 34;  // a positive discriminant fits here
    localparam int SQRT_STEPS   = 17;  // one result bit per step
    localparam int SQRT_ROOT_W  = 18;
    localparam int SQ_W         = 36;  // working width of the root stages
    localparam int OUT_FIELDS_W = 2 * ROOT_W + DISC_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOT_QUAD = 2'd0,
        KIND_ONE      = 2'd1,
        KIND_TWO      = 2'd2,
        KIND_NO_REAL  = 2'd3
    } t_kind;

    // Classification of one item, carried along with it.
    typedef struct packed {
        logic a_zero;
        logic d_zero;
        logic d_neg;
    } t_flags;

endpackage
`default_nettype wire

/* design/qrs_disc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_disc: discriminant stages
// Stage one forms b*b and a*c, stage two forms b*b - 4ac and classifies it.
// ----------------------------------------------------------------------------
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire signed [COEF_WIDTH-1:0]  i_a,
    input  wire signed [COEF_WIDTH-1:0]  i_b,
    input  wire signed [COEF_WIDTH-1:0]  i_c,
    output logic                         o_valid,
    output logic signed [COEF_WIDTH-1:0] o_a,
    output logic signed [COEF_WIDTH-1:0] o_b,
    output logic signed [DISC_W-1:0]     o_disc,
    output t_flags                       o_flags
);

    localparam int PW = 2 * COEF_WIDTH;
    localparam int XW = (PW > DISC_W + 2) ? PW : DISC_W + 2;

    logic                         r_v1;
    logic signed [COEF_WIDTH-1:0] r_a1, r_b1;
    logic signed [PW-1:0]         r_bb, r_ac;

    logic signed [XW-1:0]         n_diff;
    logic signed [DISC_W-1:0]     n_disc;
    t_flags                       n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= i_a;
            r_b1 <= i_b;
            r_bb <= i_b * i_b;
            r_ac <= i_a * i_c;
        end
    end

    // The discriminant wraps to its field width.
    always_comb begin
        n_diff         = XW'(r_bb) - (XW'(r_ac) <<< 2);
        n_disc         = n_diff[DISC_W-1:0];
        n_flags.a_zero = (r_a1 == '0);
        n_flags.d_zero = (n_disc == '0);
        n_flags.d_neg  = n_disc[DISC_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a     <= r_a1;
            o_b     <= r_b1;
            o_disc  <= n_disc;
            o_flags <= n_flags;
        end
    end

endmodule
`default_nettype wire

/* design/qrs_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One restoring step per stage, one result bit per step.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  wire                    i_valid,
    input  wire [SQRT_IN_W-1:0]    i_rad,
    input  wire [SIDE_W-1:0]       i_side,
    output logic                   o_valid,
    output logic [SQRT_ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v    [SQRT_STEPS];
    logic [SQ_W-1:0]   r_rem  [SQRT_STEPS];
    logic [SQ_W-1:0]   r_res  [SQRT_STEPS];
    logic [SIDE_W-1:0] r_side [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));

        logic              w_v_in;
        logic [SQ_W-1:0]   w_rem_in, w_res_in, w_try, n_rem, n_res;
        logic [SIDE_W-1:0] w_side_in;

        if (j == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = SQ_W'(i_rad);
            assign w_res_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[j-1];
            assign w_rem_in  = r_rem[j-1];
            assign w_res_in  = r_res[j-1];
            assign w_side_in = r_side[j-1];
        end

        always_comb begin
            w_try = w_res_in + BITV;
            if (w_rem_in >= w_try) begin
                n_rem = w_rem_in - w_try;
                n_res = (w_res_in >> 1) + BITV;
            end else begin
                n_rem = w_rem_in;
                n_res = w_res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_res[j]  <= n_res;
                r_side[j] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][SQRT_ROOT_W-1:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule
`default_nettype wire

/* design/qrs_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div: two-lane pipelined divider
// Divides two numerators, scaled by the root fraction, by one shared
// denominator: an absolute value stage, one quotient bit per stage, and a
// sign stage that truncates toward zero.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W  = 19,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 8
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire signed [NUM_W-1:0]  i_num_p,
    input  wire signed [NUM_W-1:0]  i_num_m,
    input  wire signed [DEN_W-1:0]  i_den,
    input  wire [SIDE_W-1:0]        i_side,
    output logic                    o_valid,
    output logic signed [ROOT_W-1:0] o_q_p,
    output logic signed [ROOT_W-1:0] o_q_m,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int DV = NUM_W + ROOT_FRAC;
    localparam int XQ = (DV > ROOT_W) ? DV : ROOT_W;

    // Absolute value stage.
    logic                       r0_v;
    logic [1:0][DV-1:0]         r0_sh;
    logic [1:0]                 r0_neg;
    logic [DEN_W-1:0]           r0_d;
    logic [SIDE_W-1:0]          r0_side;

    logic [1:0][NUM_W-1:0]      n0_mag;
    logic [1:0]                 n0_neg;
    logic [DEN_W-1:0]           n0_d;

    always_comb begin
        n0_mag[0] = i_num_p[NUM_W-1] ? NUM_W'(-i_num_p) : NUM_W'(i_num_p);
        n0_mag[1] = i_num_m[NUM_W-1] ? NUM_W'(-i_num_m) : NUM_W'(i_num_m);
        n0_neg[0] = i_num_p[NUM_W-1] ^ i_den[DEN_W-1];
        n0_neg[1] = i_num_m[NUM_W-1] ^ i_den[DEN_W-1];
        n0_d      = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sh[0] <= {n0_mag[0], {ROOT_FRAC{1'b0}}};
            r0_sh[1] <= {n0_mag[1], {ROOT_FRAC{1'b0}}};
            r0_neg   <= n0_neg;
            r0_d     <= n0_d;
            r0_side  <= i_side;
        end
    end

    // Quotient stages: the dividend shifts out at the top, quotient bits in
    // at the bottom.
    logic               r_v    [DV];
    logic [1:0][DV-1:0] r_sh   [DV];
    logic [1:0][DEN_W-1:0] r_rem [DV];
    logic [1:0]         r_neg  [DV];
    logic [DEN_W-1:0]   r_d    [DV];
    logic [SIDE_W-1:0]  r_side [DV];

    for (genvar k = 0; k < DV; k++) begin : g_bit
        logic                  w_v_in;
        logic [1:0][DV-1:0]    w_sh_in;
        logic [1:0][DEN_W-1:0] w_rem_in;
        logic [1:0]            w_neg_in;
        logic [DEN_W-1:0]      w_d_in;
        logic [SIDE_W-1:0]     w_side_in;
        logic [1:0][DEN_W:0]   w_trial;
        logic [1:0][DV-1:0]    n_sh;
        logic [1:0][DEN_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_v_in    = r0_v;
            assign w_sh_in   = r0_sh;
            assign w_rem_in  = '0;
            assign w_neg_in  = r0_neg;
            assign w_d_in    = r0_d;
            assign w_side_in = r0_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_sh_in   = r_sh[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_neg_in  = r_neg[k-1];
            assign w_d_in    = r_d[k-1];
            assign w_side_in = r_side[k-1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_trial[l] = {w_rem_in[l], w_sh_in[l][DV-1]};
                if (w_trial[l] >= {1'b0, w_d_in}) begin
                    n_rem[l] = DEN_W'(w_trial[l] - {1'b0, w_d_in});
                    n_sh[l]  = {w_sh_in[l][DV-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_trial[l][DEN_W-1:0];
                    n_sh[l]  = {w_sh_in[l][DV-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[k]   <= n_sh;
                r_rem[k]  <= n_rem;
                r_neg[k]  <= w_neg_in;
                r_d[k]    <= w_d_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    // Sign stage.
    logic [XQ-1:0]     w_qx_p, w_qx_m;
    logic [ROOT_W-1:0] w_mag_p, w_mag_m;

    always_comb begin
        w_qx_p  = XQ'(r_sh[DV-1][0]);
        w_qx_m  = XQ'(r_sh[DV-1][1]);
        w_mag_p = w_qx_p[ROOT_W-1:0];
        w_mag_m = w_qx_m[ROOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[DV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q_p  <= r_neg[DV-1][0] ? -w_mag_p : w_mag_p;
            o_q_m  <= r_neg[DV-1][1] ? -w_mag_m : w_mag_m;
            o_side <= r_side[DV-1];
        end
    end

endmodule
`default_nettype wire

/* design/quadratic_root_solver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x*x + b*x + c
// Fully pipelined solver: discriminant, integer square root, two-lane root
// divider, and a two-word output buffer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bits first)
//  s_axis    in         coef_a, coef_b, coef_c (signed, COEF_WIDTH each)
//  m_axis    out        tdata: root_plus, root_minus, discriminant; tuser: root_kind
//
// One word enters per clock cycle while the output buffer has room. A word passes
// through the discriminant stages, the square root stages and the divider stages
// into the output buffer; the divider depth, one quotient bit per stage, sets the
// latency.
// Reset clears only the valid bits and the buffer pointers; payload registers
// are not reset. All pipeline stages advance together while the output buffer
// has room, so a stall at the output loses and repeats no word, and new words
// are still taken while one finished word waits in the buffer.
//
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // coef_a, coef_b, coef_c, zero padding to whole bytes
    input  wire [((3*COEF_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // root_plus [39:0], root_minus [79:40], discriminant [114:80], zero padding
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // root_kind [1:0]
    output logic [KIND_W-1:0]     o_m_tuser
);

    localparam int NUM_W   = ((COEF_WIDTH > SQRT_ROOT_W) ? COEF_WIDTH : SQRT_ROOT_W) + 1;
    localparam int DEN_W   = COEF_WIDTH + 1;
    localparam int SIDE1_W = 2 * COEF_WIDTH + DISC_W + $bits(t_flags);
    localparam int SIDE2_W = DISC_W + $bits(t_flags);
    localparam int ENTRY_W = OUT_DATA_W + KIND_W;

    // Global advance: every stage moves when the buffer can take a word.
    logic w_en;

    // Discriminant stages.
    logic                         d_valid;
    logic signed [COEF_WIDTH-1:0] d_a, d_b;
    logic signed [DISC_W-1:0]     d_disc;
    t_flags                       d_flags;

    qrs_disc #(.COEF_WIDTH(COEF_WIDTH)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_a     (i_s_tdata[COEF_WIDTH-1:0]),
        .i_b     (i_s_tdata[2*COEF_WIDTH-1:COEF_WIDTH]),
        .i_c     (i_s_tdata[3*COEF_WIDTH-1:2*COEF_WIDTH]),
        .o_valid (d_valid),
        .o_a     (d_a),
        .o_b     (d_b),
        .o_disc  (d_disc),
        .o_flags (d_flags)
    );

    // Only a positive discriminant is rooted; otherwise the root is zero,
    // which also makes the plus lane give -b/(2a) for a double root.
    logic [SQRT_IN_W-1:0] w_rad;
    assign w_rad = (d_flags.d_neg || d_flags.d_zero) ? '0 : d_disc[SQRT_IN_W-1:0];

    logic                   s_valid;
    logic [SQRT_ROOT_W-1:0] s_root;
    logic [SIDE1_W-1:0]     s_side;

    qrs_sqrt #(.SIDE_W(SIDE1_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d_valid),
        .i_rad   (w_rad),
        .i_side  ({d_a, d_b, d_disc, d_flags}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Numerators -b +/- S and the denominator 2a.
    logic signed [COEF_WIDTH-1:0] s_a, s_b;
    logic [SIDE2_W-1:0]           s_rest;
    logic signed [NUM_W-1:0]      w_nb, w_s, w_num_p, w_num_m;
    logic signed [DEN_W-1:0]      w_den;

    always_comb begin
        {s_a, s_b, s_rest} = s_side;
        w_nb    = -NUM_W'(s_b);
        w_s     = NUM_W'(s_root);
        w_num_p = w_nb + w_s;
        w_num_m = w_nb - w_s;
        w_den   = {s_a, 1'b0};
    end

    logic                     q_valid;
    logic signed [ROOT_W-1:0] q_p, q_m;
    logic [SIDE2_W-1:0]       q_side;

    qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE2_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_valid),
        .i_num_p (w_num_p),
        .i_num_m (w_num_m),
        .i_den   (w_den),
        .i_side  (s_rest),
        .o_valid (q_valid),
        .o_q_p   (q_p),
        .o_q_m   (q_m),
        .o_side  (q_side)
    );

    // Final result: pick the root kind and blank the fields it leaves unused.
    logic signed [DISC_W-1:0] q_disc;
    t_flags                   q_flags;
    t_kind                    w_kind;
    logic [ROOT_W-1:0]        w_plus, w_minus;
    logic [DISC_W-1:0]        w_disc;
    logic [ENTRY_W-1:0]       w_entry;

    always_comb begin
        {q_disc, q_flags} = q_side;
        if (q_flags.a_zero) begin
            w_kind = KIND_NOT_QUAD;
        end else if (q_flags.d_zero) begin
            w_kind = KIND_ONE;
        end else if (q_flags.d_neg) begin
            w_kind = KIND_NO_REAL;
        end else begin
            w_kind = KIND_TWO;
        end
        w_plus  = (w_kind == KIND_ONE || w_kind == KIND_TWO) ? q_p : '0;
        w_minus = (w_kind == KIND_TWO) ? q_m : '0;
        w_disc  = q_flags.a_zero ? '0 : q_disc;
        w_entry = {w_kind, OUT_DATA_W'({w_disc, w_minus, w_plus})};
    end

    // Two-word output buffer.
    logic [ENTRY_W-1:0] r_buf [2];
    logic [1:0]         r_cnt;
    logic               r_wr, r_rd;
    logic               w_push, w_pop;

    assign w_en   = (r_cnt != 2'd2);
    assign w_push = w_en && q_valid;
    assign w_pop  = (r_cnt != 2'd0) && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_entry;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_buf[r_rd][OUT_DATA_W-1:0];
    assign o_m_tuser  = r_buf[r_rd][ENTRY_W-1:OUT_DATA_W];

`ifndef SYNTH
    // Two real roots require a strictly positive discriminant.
    a_two_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_TWO) |->
        (!o_m_tdata[2*ROOT_W+DISC_W-1] && o_m_tdata[2*ROOT_W+DISC_W-1:2*ROOT_W] != '0))
        else $error("two roots reported with a discriminant that is not positive");

    // A degenerate quadratic carries an all-zero word.
    a_not_quad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_NOT_QUAD) |-> (o_m_tdata == '0))
        else $error("nonzero fields for a zero leading coefficient");

    // No real roots: both root fields are zero.
    a_no_real_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_NO_REAL) |-> (o_m_tdata[2*ROOT_W-1:0] == '0))
        else $error("root fields set with no real roots");

    // The buffer never overfills.
    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |=> (r_cnt != 2'd3))
        else $error("output buffer count out of range");
`endif

endmodule
`default_nettype wire
